### design/h264_fu_a_packetizer_core_assert.svh
// assertion macros for the fu-a packetizer
`ifndef H264_FU_A_PACKETIZER_CORE_ASSERT_SVH
`define H264_FU_A_PACKETIZER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define H264FU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h264fu assertion failed");

// next-cycle implication, disabled during reset
`define H264FU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h264fu assertion failed");

`endif

### design/h264fu_pkg.sv
// types and constants shared by the fu-a packetizer modules
package h264fu_pkg;

   // result queue geometry
   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_BITS = 3;
   localparam int RSP_CNT_BITS = 4;
   localparam int MAX_PUSH     = 3;
   localparam int PUSH_BITS    = 2;

   // fu-a codes
   localparam logic [7:0] FU_A_TYPE  = 8'd28;
   localparam logic [7:0] NRI_MASK   = 8'hE0;
   localparam logic [7:0] TYPE_MASK  = 8'h1F;
   localparam logic [7:0] START_BIT  = 8'h80;
   localparam logic [7:0] END_BIT    = 8'h40;

   // payload limit
   localparam logic [15:0] LIMIT_FLOOR = 16'd3;
   localparam logic [15:0] LIMIT_RESET = 16'd1420;
   localparam logic [15:0] FU_OVERHEAD = 16'd2;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        packet_first;
      logic        packet_last;
      logic        marker;
      logic [31:0] stamp;
      logic [7:0]  kind;
      logic [7:0]  channel;
      logic        run_last;
   } rsp_type;

endpackage

### design/h264_fu_a_packetizer_core.sv
// top level of the h.264 fu-a packetizer
// Takes one NAL byte per item, header byte first; the size, marker, timestamp,
// kind and channel are captured on the byte flagged req_nal_first. A NAL no
// larger than csr max_payload (floored at 3) passes through as one packet with
// the caller's marker. A larger NAL has its header byte held back and is cut
// into fu-a fragments of at most max_payload-2 data bytes, each led by an fu
// indicator and an fu header (start bit on the first, end bit and marker on
// the last). The fragment split is fixed at the first data byte of each
// fragment from the current register value. Rate: one input byte is taken
// per cycle unless req_stall; each input produces 0, 1 or 3 result items
// into an 8-entry result queue that drains one item per cycle unless
// rsp_stall. A byte that opens a fragment yields three items, so long runs of
// small fragments are limited by the single output port; req_stall rises
// while fewer than three queue slots are free. A byte with nal_first low and
// no open NAL is dropped, and a new nal_first abandons an unfinished NAL. csr
// writes are always ready and must only happen while the block is idle.
`include "h264_fu_a_packetizer_core_assert.svh"

module h264_fu_a_packetizer_core #(
   parameter int SIZE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,

   // configuration: max_payload
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data,

   // nal byte items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_nal_byte,
   input  logic                 req_nal_first,
   input  logic [SIZE_BITS-1:0] req_nal_size,
   input  logic                 req_frame_marker,
   input  logic [31:0]          req_stamp_in,
   input  logic [7:0]           req_kind_in,
   input  logic [7:0]           req_channel_in,

   // payload byte items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_packet_first,
   output logic                 rsp_packet_last,
   output logic                 rsp_marker,
   output logic [31:0]          rsp_stamp_out,
   output logic [7:0]           rsp_kind_out,
   output logic [7:0]           rsp_channel_out,
   output logic                 rsp_run_last
);

   // configuration register
   logic [15:0]          max_payload_ff;

   // packetizer state
   logic                 fragmenting_ff, fragmenting_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [15:0]          frag_count_ff, frag_count_in;
   logic [7:0]           header_hold_ff, header_hold_in;
   logic                 first_frag_ff, first_frag_in;
   logic                 final_frag_ff, final_frag_in;
   logic [31:0]          stamp_hold_ff, stamp_hold_in;
   logic                 marker_hold_ff, marker_hold_in;
   logic [7:0]           kind_hold_ff, kind_hold_in;
   logic [7:0]           channel_hold_ff, channel_hold_in;

   // per-item working values
   logic                 req_take;
   logic                 space_ok;
   logic [15:0]          limit;
   logic [SIZE_BITS:0]   limit_ext;
   logic [SIZE_BITS-1:0] size_fix;
   logic                 size_fits;
   logic [15:0]          frag_cur;
   logic [15:0]          frag_next;
   logic                 final_cur;
   logic [h264fu_pkg::PUSH_BITS-1:0] push_n;
   h264fu_pkg::rsp_type  push_item [h264fu_pkg::MAX_PUSH];
   h264fu_pkg::rsp_type  base_item;
   h264fu_pkg::rsp_type  out_item;

   assign csr_ready = 1'b1;
   assign req_stall = !space_ok;
   assign req_take  = req_valid && space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= h264fu_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         max_payload_ff <= csr_data;
      end
   end

   // effective limit and first-byte size check
   assign limit     = (max_payload_ff < h264fu_pkg::LIMIT_FLOOR) ? h264fu_pkg::LIMIT_FLOOR
                                                                 : max_payload_ff;
   assign limit_ext = (SIZE_BITS + 1)'(limit);
   assign size_fix  = (req_nal_size == '0) ? SIZE_BITS'(1) : req_nal_size;
   assign size_fits = (SIZE_BITS + 1)'(size_fix) <= limit_ext;

   always_comb begin
      fragmenting_in  = fragmenting_ff;
      bytes_left_in   = bytes_left_ff;
      frag_count_in   = frag_count_ff;
      header_hold_in  = header_hold_ff;
      first_frag_in   = first_frag_ff;
      final_frag_in   = final_frag_ff;
      stamp_hold_in   = stamp_hold_ff;
      marker_hold_in  = marker_hold_ff;
      kind_hold_in    = kind_hold_ff;
      channel_hold_in = channel_hold_ff;
      frag_cur        = frag_count_ff;
      final_cur       = final_frag_ff;
      frag_next       = frag_count_ff - 16'd1;
      push_n          = '0;

      if (req_take && req_nal_first) begin
         stamp_hold_in   = req_stamp_in;
         marker_hold_in  = req_frame_marker;
         kind_hold_in    = req_kind_in;
         channel_hold_in = req_channel_in;
      end

      // fields common to every result of this item use the updated holds
      base_item              = '0;
      base_item.stamp        = stamp_hold_in;
      base_item.kind         = kind_hold_in;
      base_item.channel      = channel_hold_in;
      for (int k = 0; k < h264fu_pkg::MAX_PUSH; k++) begin
         push_item[k] = base_item;
      end

      if (req_take) begin
         if (req_nal_first) begin
            bytes_left_in = size_fix - SIZE_BITS'(1);
            if (size_fits) begin
               // whole nal in one packet
               fragmenting_in            = 1'b0;
               push_item[0].payload_byte = req_nal_byte;
               push_item[0].packet_first = 1'b1;
               push_item[0].packet_last  = size_fix == SIZE_BITS'(1);
               push_item[0].marker       = req_frame_marker;
               push_item[0].run_last     = 1'b1;
               push_n                    = h264fu_pkg::PUSH_BITS'(1);
            end else begin
               // hold the header, no output
               fragmenting_in = 1'b1;
               header_hold_in = req_nal_byte;
               frag_count_in  = '0;
               first_frag_in  = 1'b1;
               final_frag_in  = 1'b0;
            end
         end else if (bytes_left_ff != '0) begin
            bytes_left_in = bytes_left_ff - SIZE_BITS'(1);
            if (!fragmenting_ff) begin
               push_item[0].payload_byte = req_nal_byte;
               push_item[0].packet_last  = bytes_left_ff == SIZE_BITS'(1);
               push_item[0].marker       = marker_hold_ff;
               push_item[0].run_last     = 1'b1;
               push_n                    = h264fu_pkg::PUSH_BITS'(1);
            end else begin
               if (frag_count_ff == '0) begin
                  // new fragment: size it from the current limit
                  if ((SIZE_BITS + 1)'(bytes_left_ff) + (SIZE_BITS + 1)'(2) > limit_ext) begin
                     frag_cur  = limit - h264fu_pkg::FU_OVERHEAD;
                     final_cur = 1'b0;
                  end else begin
                     frag_cur  = bytes_left_ff[15:0];
                     final_cur = 1'b1;
                  end
                  first_frag_in = 1'b0;
               end
               frag_next     = frag_cur - 16'd1;
               final_frag_in = final_cur;

               if (frag_count_ff == '0) begin
                  // fu indicator, fu header, then the data byte
                  push_item[0].payload_byte = (header_hold_ff & h264fu_pkg::NRI_MASK)
                                              | h264fu_pkg::FU_A_TYPE;
                  push_item[0].packet_first = 1'b1;
                  push_item[0].marker       = final_cur;
                  push_item[1].payload_byte = (first_frag_ff ? h264fu_pkg::START_BIT : 8'h00)
                                              | (final_cur ? h264fu_pkg::END_BIT : 8'h00)
                                              | (header_hold_ff & h264fu_pkg::TYPE_MASK);
                  push_item[1].marker       = final_cur;
                  push_item[2].payload_byte = req_nal_byte;
                  push_item[2].packet_last  = frag_next == '0;
                  push_item[2].marker       = final_cur;
                  push_item[2].run_last     = 1'b1;
                  push_n                    = h264fu_pkg::PUSH_BITS'(3);
               end else begin
                  push_item[0].payload_byte = req_nal_byte;
                  push_item[0].packet_last  = frag_next == '0;
                  push_item[0].marker       = final_cur;
                  push_item[0].run_last     = 1'b1;
                  push_n                    = h264fu_pkg::PUSH_BITS'(1);
               end

               if (bytes_left_ff == SIZE_BITS'(1)) begin
                  // nal done
                  fragmenting_in = 1'b0;
                  frag_count_in  = '0;
               end else begin
                  frag_count_in = frag_next;
               end
            end
         end
         // stray byte with no open nal: dropped
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fragmenting_ff  <= 1'b0;
         bytes_left_ff   <= '0;
         frag_count_ff   <= '0;
         header_hold_ff  <= '0;
         first_frag_ff   <= 1'b0;
         final_frag_ff   <= 1'b0;
         stamp_hold_ff   <= '0;
         marker_hold_ff  <= 1'b0;
         kind_hold_ff    <= '0;
         channel_hold_ff <= '0;
      end else begin
         fragmenting_ff  <= fragmenting_in;
         bytes_left_ff   <= bytes_left_in;
         frag_count_ff   <= frag_count_in;
         header_hold_ff  <= header_hold_in;
         first_frag_ff   <= first_frag_in;
         final_frag_ff   <= final_frag_in;
         stamp_hold_ff   <= stamp_hold_in;
         marker_hold_ff  <= marker_hold_in;
         kind_hold_ff    <= kind_hold_in;
         channel_hold_ff <= channel_hold_in;
      end
   end

   // result queue decouples the byte input from the packet output
   h264fu_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_item (push_item),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (out_item)
   );

   assign rsp_payload_byte = out_item.payload_byte;
   assign rsp_packet_first = out_item.packet_first;
   assign rsp_packet_last  = out_item.packet_last;
   assign rsp_marker       = out_item.marker;
   assign rsp_stamp_out    = out_item.stamp;
   assign rsp_kind_out     = out_item.kind;
   assign rsp_channel_out  = out_item.channel;
   assign rsp_run_last     = out_item.run_last;

   // an open fragmented nal always has bytes still to come
   `H264FU_ASSERT_NOW(a_frag_has_bytes, clock, reset, fragmenting_ff, bytes_left_ff != '0)
   // the current fragment never runs past the end of the nal
   `H264FU_ASSERT_NOW(a_frag_within_nal, clock, reset, fragmenting_ff,
      SIZE_BITS'(frag_count_ff) <= bytes_left_ff)
   // a nal that fits leaves the block unfragmented with a single result
   `H264FU_ASSERT_NEXT(a_fit_single, clock, reset,
      req_take && req_nal_first && size_fits, !fragmenting_ff)

endmodule

### design/h264fu_rsp_fifo.sv
// result queue: takes up to three items a cycle, gives one a cycle while out_stall is low
`include "h264_fu_a_packetizer_core_assert.svh"

module h264fu_rsp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [h264fu_pkg::PUSH_BITS-1:0]     push_n,
   input  h264fu_pkg::rsp_type                  push_item [h264fu_pkg::MAX_PUSH],
   output logic                                 space_ok,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output h264fu_pkg::rsp_type                  out_item
);

   h264fu_pkg::rsp_type                    entry_ff [h264fu_pkg::RSP_DEPTH];
   logic [h264fu_pkg::RSP_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [h264fu_pkg::RSP_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [h264fu_pkg::RSP_CNT_BITS-1:0]    count_ff, count_in;
   logic                                   pop;

   // room for a worst-case item of three results
   assign space_ok  = count_ff <= h264fu_pkg::RSP_CNT_BITS'(h264fu_pkg::RSP_DEPTH
                                                          - h264fu_pkg::MAX_PUSH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + h264fu_pkg::RSP_PTR_BITS'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + h264fu_pkg::RSP_CNT_BITS'(push_n)
                  - h264fu_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < h264fu_pkg::MAX_PUSH; k++) begin
         if (h264fu_pkg::PUSH_BITS'(k) < push_n) begin
            entry_ff[h264fu_pkg::RSP_PTR_BITS'(wr_ptr_ff + h264fu_pkg::RSP_PTR_BITS'(k))]
               <= push_item[k];
         end
      end
   end

   `H264FU_ASSERT_NOW(a_push_has_room, clock, reset, push_n != '0, space_ok)
   `H264FU_ASSERT_NEXT(a_stalled_head_holds, clock, reset,
      out_valid && out_stall, out_valid && $stable(rd_ptr_ff))
   `H264FU_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1,
      count_ff <= h264fu_pkg::RSP_CNT_BITS'(h264fu_pkg::RSP_DEPTH))

endmodule
